FILE: design/first_fit_frame_allocator_core_defines.svh
// Assertion macros shared by the checker of the first-fit frame allocator.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef FIRST_FIT_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ffa_pkg.sv
// Shared types and constants of the first-fit frame allocator.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package ffa_pkg;

    // Default number of frames in the occupancy map.
    localparam int NUM_FRAMES_DEF = 64;

    // Field widths fixed by the interface.
    localparam int CMD_W    = 1;
    localparam int START_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 7;
    localparam int SPACE_W  = 19;
    localparam int FSIZE_W  = 13;

    // Saturation limits of the report fields.
    localparam int FREE_MAX  = 127;
    localparam int SPACE_MAX = 524287;

    // Request codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

    // Configuration register index and bus width.
    localparam int          APB_AW         = 3;
    localparam logic        REG_FRAME_SIZE = 1'b0;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_MULT,
        ST_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch a new request and clear the pass state
        logic scan;      // rotate the map one frame, searching for a fit
        logic apply;     // rotate the map one frame, writing the run
        logic mult;      // form free frames times frame size
        logic load_out;  // register the result fields and strobe them
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pos_last;  // the current frame is the last one of a pass
    } t_dp_status;

endpackage

FILE: design/ffa_ctrl.sv
// Controller of the first-fit frame allocator: sequences the scan and apply passes.
// Depends on ffa_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps

module ffa_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ffa_pkg::CMD_W-1:0]       i_command,
    input  ffa_pkg::t_dp_status             i_status,
    output ffa_pkg::t_dp_cmd                o_cmd,
    output logic                            o_busy
);

    ffa_pkg::t_state r_state;
    ffa_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ffa_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_command == ffa_pkg::CMD_ALLOC) ? ffa_pkg::ST_SCAN
                                                                : ffa_pkg::ST_APPLY;
                end
            end
            ffa_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.pos_last) begin
                    n_state = ffa_pkg::ST_APPLY;
                end
            end
            ffa_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
                if (i_status.pos_last) begin
                    n_state = ffa_pkg::ST_MULT;
                end
            end
            ffa_pkg::ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state = ffa_pkg::ST_RESP;
            end
            ffa_pkg::ST_RESP: begin
                o_cmd.load_out = 1'b1;
                n_state = ffa_pkg::ST_IDLE;
            end
            default: begin
                n_state = ffa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ffa_pkg::ST_IDLE);

endmodule

FILE: design/ffa_datapath.sv
// Datapath of the first-fit frame allocator: rotating occupancy map, run search,
// free count, free space product and result registers. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_datapath #(
    parameter int NUM_FRAMES = ffa_pkg::NUM_FRAMES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ffa_pkg::t_dp_cmd                  i_cmd,
    output ffa_pkg::t_dp_status               o_status,
    input  logic [ffa_pkg::CMD_W-1:0]         i_command,
    input  logic [ffa_pkg::START_W-1:0]       i_start_frame,
    input  logic [ffa_pkg::COUNT_W-1:0]       i_frame_count,
    input  logic [ffa_pkg::FSIZE_W-1:0]       i_frame_size,
    output logic                              o_result_valid,
    output logic [ffa_pkg::STATUS_W-1:0]      o_status_code,
    output logic [ffa_pkg::START_W-1:0]       o_granted_frame,
    output logic [ffa_pkg::FREE_W-1:0]        o_free_frames,
    output logic [ffa_pkg::SPACE_W-1:0]       o_free_space
);

    // Widths of the frame index, the frame count, the range-check arithmetic and the product.
    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int AW = (CW > 8) ? CW : 8;
    localparam int PW = (CW + ffa_pkg::FSIZE_W > 20) ? CW + ffa_pkg::FSIZE_W : 20;

    logic [NUM_FRAMES-1:0]          r_map;
    logic [IW-1:0]                  r_pos;
    logic [AW-1:0]                  r_run;
    logic [AW-1:0]                  r_lo;
    logic                           r_ok;
    logic                           r_is_alloc;
    logic [ffa_pkg::COUNT_W-1:0]    r_count;
    logic [CW-1:0]                  r_nfree;
    logic [PW-1:0]                  r_product;
    logic                           r_strobe;
    logic [ffa_pkg::STATUS_W-1:0]   r_status;
    logic [ffa_pkg::START_W-1:0]    r_granted;
    logic [ffa_pkg::FREE_W-1:0]     r_free;
    logic [ffa_pkg::SPACE_W-1:0]    r_space;

    logic                           map_bit;
    logic [AW-1:0]                  count_ext;
    logic [AW-1:0]                  pos_ext;
    logic [AW-1:0]                  run_next;
    logic [AW-1:0]                  hi;
    logic                           hit;
    logic                           in_run;
    logic                           new_bit;
    logic                           free_ok;
    logic                           pos_last;

    // Frame under examination sits at bit 0 of the rotating map.
    always_comb begin
        map_bit   = r_map[0];
        count_ext = AW'(r_count);
        pos_ext   = AW'(r_pos);
        run_next  = map_bit ? '0 : (r_run + AW'(1));
        hit       = i_cmd.scan && !r_ok && (count_ext != '0) && (run_next == count_ext);
        hi        = r_lo + count_ext;
        in_run    = r_ok && (pos_ext >= r_lo) && (pos_ext < hi);
        new_bit   = in_run ? r_is_alloc : map_bit;
        pos_last  = (r_pos == IW'(NUM_FRAMES - 1));
        free_ok   = (i_frame_count != '0) &&
                    ((AW'(i_start_frame) + AW'(i_frame_count)) <= AW'(NUM_FRAMES));
    end

    assign o_status.pos_last = pos_last;

    // Occupancy map: rotates one frame per cycle during either pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_cmd.scan || i_cmd.apply) begin
            r_map <= {(i_cmd.apply ? new_bit : map_bit), r_map[NUM_FRAMES-1:1]};
        end
    end

    // Request, frame position, run search and free count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos      <= '0;
            r_run      <= '0;
            r_nfree    <= '0;
            r_count    <= i_frame_count;
            r_is_alloc <= (i_command == ffa_pkg::CMD_ALLOC);
            if (i_command == ffa_pkg::CMD_ALLOC) begin
                r_ok <= 1'b0;
                r_lo <= '0;
            end else begin
                r_ok <= free_ok;
                r_lo <= AW'(i_start_frame);
            end
        end else begin
            if (i_cmd.scan || i_cmd.apply) begin
                r_pos <= pos_last ? '0 : (r_pos + IW'(1));
            end
            if (i_cmd.scan) begin
                r_run <= run_next;
            end
            if (hit) begin
                r_ok <= 1'b1;
                r_lo <= pos_ext + AW'(1) - count_ext;
            end
            if (i_cmd.apply && !new_bit) begin
                r_nfree <= r_nfree + CW'(1);
            end
        end
    end

    // Free space product, registered ahead of saturation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_product <= PW'(r_nfree) * PW'(i_frame_size);
        end
    end

    // Result fields with saturation of the report values.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_ok) begin
                r_status <= ffa_pkg::STATUS_DONE;
            end else if (r_is_alloc && (r_count != '0)) begin
                r_status <= ffa_pkg::STATUS_NOFIT;
            end else begin
                r_status <= ffa_pkg::STATUS_BAD;
            end
            r_granted <= r_ok ? r_lo[ffa_pkg::START_W-1:0] : '0;
            r_free    <= (AW'(r_nfree) > AW'(ffa_pkg::FREE_MAX)) ?
                         ffa_pkg::FREE_W'(ffa_pkg::FREE_MAX) : r_nfree[ffa_pkg::FREE_W-1:0];
            r_space   <= (r_product > PW'(ffa_pkg::SPACE_MAX)) ?
                         ffa_pkg::SPACE_W'(ffa_pkg::SPACE_MAX) : r_product[ffa_pkg::SPACE_W-1:0];
        end
    end

    // One-cycle result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.load_out;
        end
    end

    assign o_result_valid  = r_strobe;
    assign o_status_code   = r_status;
    assign o_granted_frame = r_granted;
    assign o_free_frames   = r_free;
    assign o_free_space    = r_space;

endmodule

FILE: design/first_fit_frame_allocator_core.sv
// Top level of the first-fit frame allocator: configuration register, controller
// and datapath. Depends on ffa_pkg, ffa_ctrl and ffa_datapath.
//
//   Channel   Handshake                         Fields
//   request   start high while busy low         i_command, i_start_frame, i_frame_count
//   result    o_result_valid, one cycle         o_status, o_granted_frame,
//                                               o_free_frames, o_free_space
//   config    psel & penable & pwrite (APB)     frame_size at byte address 0
//
// An allocate request, granted or not, runs a search pass and a write pass, a free
// request the write pass only; each then forms the free space product and result.
// The map rotates one frame per cycle past a single examination point in each pass.
// busy is high from the transfer until the cycle the result strobe shows.
// Reset is synchronous, active low, and marks every frame free, frame_size 1.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module first_fit_frame_allocator_core #(
    parameter int NUM_FRAMES = ffa_pkg::NUM_FRAMES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ffa_pkg::CMD_W-1:0]       i_command,
    input  logic [ffa_pkg::START_W-1:0]     i_start_frame,
    input  logic [ffa_pkg::COUNT_W-1:0]     i_frame_count,
    output logic                            o_result_valid,
    output logic [ffa_pkg::STATUS_W-1:0]    o_status,
    output logic [ffa_pkg::START_W-1:0]     o_granted_frame,
    output logic [ffa_pkg::FREE_W-1:0]      o_free_frames,
    output logic [ffa_pkg::SPACE_W-1:0]     o_free_space,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffa_pkg::APB_AW-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [ffa_pkg::FSIZE_W-1:0]  r_frame_size;
    logic                         reg_hit;
    ffa_pkg::t_dp_cmd             dp_cmd;
    ffa_pkg::t_dp_status          dp_status;

    // Configuration register; the byte offset bits are ignored.
    assign reg_hit = (paddr[2] == ffa_pkg::REG_FRAME_SIZE);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? 32'(r_frame_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= ffa_pkg::FSIZE_W'(1);
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_frame_size <= pwdata[ffa_pkg::FSIZE_W-1:0];
        end
    end

    // Sequencer.
    ffa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd),
        .o_busy    (busy)
    );

    // Map, search and report.
    ffa_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_command       (i_command),
        .i_start_frame   (i_start_frame),
        .i_frame_count   (i_frame_count),
        .i_frame_size    (r_frame_size),
        .o_result_valid  (o_result_valid),
        .o_status_code   (o_status),
        .o_granted_frame (o_granted_frame),
        .o_free_frames   (o_free_frames),
        .o_free_space    (o_free_space)
    );

endmodule

FILE: design/ffa_checker.sv
// Port-level checker of the first-fit frame allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_frame_allocator_core_defines.svh.
`timescale 1ns / 1ps
`include "first_fit_frame_allocator_core_defines.svh"

module ffa_port_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            o_result_valid,
    input  logic [ffa_pkg::STATUS_W-1:0]    o_status,
    input  logic [ffa_pkg::START_W-1:0]     o_granted_frame
);

    // A request transfer makes the block busy in the next cycle.
    `FFA_ASSERT_NEXT(a_busy_after_start, start && !busy, busy,
        "busy did not rise after a transfer")

    // Results are single-cycle pulses.
    `FFA_ASSERT_NEXT(a_strobe_single, o_result_valid, !o_result_valid,
        "result strobe held over two cycles")

    // Only the three defined status codes appear.
    `FFA_ASSERT_NOW(a_status_code, o_result_valid,
        (o_status == ffa_pkg::STATUS_DONE) || (o_status == ffa_pkg::STATUS_NOFIT) ||
        (o_status == ffa_pkg::STATUS_BAD), "undefined status code")

    // A failed request reports start frame zero.
    `FFA_ASSERT_NOW(a_fail_zero_start, o_result_valid && (o_status != ffa_pkg::STATUS_DONE),
        o_granted_frame == '0, "failed request reported a nonzero start frame")

endmodule

bind first_fit_frame_allocator_core ffa_port_checker u_ffa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_valid  (o_result_valid),
    .o_status        (o_status),
    .o_granted_frame (o_granted_frame)
);

FILE: verif/ffa_checker.sv
`timescale 1ns / 1ps
// Checker of the first-fit frame allocator: it mirrors the occupancy map and
// frame size, predicts each report and compares it with the block's output.
// Depends on ffa_pkg; it only watches ports and never drives the block.

module ffa_checker
    import ffa_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [START_W-1:0]  i_start_frame,
    input  logic [COUNT_W-1:0]  i_frame_count,
    input  logic                o_result_valid,
    input  logic [STATUS_W-1:0] o_status,
    input  logic [START_W-1:0]  o_granted_frame,
    input  logic [FREE_W-1:0]   o_free_frames,
    input  logic [SPACE_W-1:0]  o_free_space,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    output int                  o_error_count,
    output int                  o_pending
);

    // One report of the allocator, field for field.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  granted;
        logic [FREE_W-1:0]   free_frames;
        logic [SPACE_W-1:0]  free_space;
    } t_alloc_report;

    logic [NUM_FRAMES-1:0] frame_in_use;
    logic [FSIZE_W-1:0]    frame_size_kb;
    t_alloc_report         awaited_reports[$];
    int                    error_count = 0;
    int                    pending_count = 0;

    assign o_error_count = error_count;
    assign o_pending     = pending_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Applies one request to the mirrored map and works out its report.
    task automatic serve_request(
        input  logic [CMD_W-1:0]   cmd,
        input  logic [START_W-1:0] first,
        input  logic [COUNT_W-1:0] count,
        output t_alloc_report      rep
    );
        int     base;
        int     len;
        int     nfree;
        int     i;
        int     j;
        bit     fits;
        longint space;
        rep        = '0;
        rep.status = STATUS_BAD;
        base       = int'(first);
        len        = int'(count);
        if (len != 0) begin
            if (cmd == CMD_ALLOC) begin
                // Lowest start whose whole run lies free inside memory.
                rep.status = STATUS_NOFIT;
                for (i = 0; i + len <= NUM_FRAMES; i++) begin
                    if (rep.status == STATUS_NOFIT) begin
                        fits = 1'b1;
                        for (j = 0; j < len; j++) begin
                            if (frame_in_use[i+j]) begin
                                fits = 1'b0;
                            end
                        end
                        if (fits) begin
                            for (j = 0; j < len; j++) begin
                                frame_in_use[i+j] = 1'b1;
                            end
                            rep.status  = STATUS_DONE;
                            rep.granted = i[START_W-1:0];
                        end
                    end
                end
            end else if (base + len <= NUM_FRAMES) begin
                // Freeing frames that are already free leaves them free.
                for (j = 0; j < len; j++) begin
                    frame_in_use[base+j] = 1'b0;
                end
                rep.status  = STATUS_DONE;
                rep.granted = first;
            end
        end
        nfree = NUM_FRAMES - $countones(frame_in_use);
        space = longint'(nfree) * longint'(frame_size_kb);
        if (space > longint'(SPACE_MAX)) begin
            space = longint'(SPACE_MAX);
        end
        if (nfree > FREE_MAX) begin
            nfree = FREE_MAX;
        end
        rep.free_frames = nfree[FREE_W-1:0];
        rep.free_space  = space[SPACE_W-1:0];
    endtask

    // Results are checked before a new transfer is predicted, since a result
    // strobe and the next request transfer may share one clock edge.
    always @(posedge i_clk) begin
        t_alloc_report want;
        t_alloc_report fresh;
        if (!i_rst_n) begin
            frame_in_use  = '0;
            frame_size_kb = FSIZE_W'(1);
            awaited_reports.delete();
        end else begin
            if (o_result_valid) begin
                if (awaited_reports.size() == 0) begin
                    report_mismatch("result strobe with no request outstanding");
                end else begin
                    want = awaited_reports.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                            o_status, want.status));
                    end
                    if (o_granted_frame !== want.granted) begin
                        report_mismatch($sformatf("granted_frame %0d, expected %0d",
                            o_granted_frame, want.granted));
                    end
                    if (o_free_frames !== want.free_frames) begin
                        report_mismatch($sformatf("free_frames %0d, expected %0d",
                            o_free_frames, want.free_frames));
                    end
                    if (o_free_space !== want.free_space) begin
                        report_mismatch($sformatf("free_space %0d, expected %0d",
                            o_free_space, want.free_space));
                    end
                end
            end
            if (start && !busy) begin
                serve_request(i_command, i_start_frame, i_frame_count, fresh);
                awaited_reports.insert(awaited_reports.size(), fresh);
            end
            // Register transfers; writes to unknown registers are dropped.
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[APB_AW-1:2] == REG_FRAME_SIZE) begin
                        frame_size_kb = pwdata[FSIZE_W-1:0];
                    end
                end else if (paddr[APB_AW-1:2] == REG_FRAME_SIZE &&
                             prdata !== 32'(frame_size_kb)) begin
                    report_mismatch($sformatf("frame_size read %0d, expected %0d",
                        prdata, frame_size_kb));
                end
            end
        end
        pending_count = awaited_reports.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the first-fit frame allocator testbench: clock, reset, request and
// register stimulus, watchdog and verdict. Depends on ffa_pkg, ffa_checker
// and first_fit_frame_allocator_core.

module testbench;
    import ffa_pkg::*;

    localparam int   NUM_FRAMES    = NUM_FRAMES_DEF;
    localparam int   STALL_LIMIT   = 5000;
    localparam int   SETTLE_CYCLES = 2 * NUM_FRAMES + 8;
    localparam int   PHASE_ITEMS   = 177;
    localparam logic REG_SPARE     = 1'b1;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    i_command;
    logic [START_W-1:0]  i_start_frame;
    logic [COUNT_W-1:0]  i_frame_count;
    logic                o_result_valid;
    logic [STATUS_W-1:0] o_status;
    logic [START_W-1:0]  o_granted_frame;
    logic [FREE_W-1:0]   o_free_frames;
    logic [SPACE_W-1:0]  o_free_space;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    int                  error_count;
    int                  pending;
    int                  idle_pct;
    int                  quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    first_fit_frame_allocator_core #(
        .NUM_FRAMES(NUM_FRAMES)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_start_frame(i_start_frame),
        .i_frame_count(i_frame_count), .o_result_valid(o_result_valid),
        .o_status(o_status), .o_granted_frame(o_granted_frame),
        .o_free_frames(o_free_frames), .o_free_space(o_free_space),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ffa_checker #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_start_frame(i_start_frame),
        .i_frame_count(i_frame_count), .o_result_valid(o_result_valid),
        .o_status(o_status), .o_granted_frame(o_granted_frame),
        .o_free_frames(o_free_frames), .o_free_space(o_free_space),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .o_error_count(error_count), .o_pending(pending)
    );

    // Watchdog: too long without any request or result transfer ends the run.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [APB_AW-1:0] reg_addr(input logic index);
        return APB_AW'({index, 2'b00});
    endfunction

    // Holds a request on the ports until the block takes it.
    task automatic send_request(
        input logic [CMD_W-1:0]   cmd,
        input logic [START_W-1:0] first,
        input logic [COUNT_W-1:0] count
    );
        i_command     = cmd;
        i_start_frame = first;
        i_frame_count = count;
        start         = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Random sender gaps, now and then a long one, with junk on the fields.
    task automatic idle_sender();
        while ($urandom_range(99) < idle_pct) begin
            start         = 1'b0;
            i_command     = CMD_W'($urandom);
            i_start_frame = START_W'($urandom);
            i_frame_count = COUNT_W'($urandom);
            if ($urandom_range(7) == 0) begin
                repeat ($urandom_range(1, 150)) @(negedge i_clk);
            end else begin
                @(negedge i_clk);
            end
        end
    endtask

    // Waits until every outstanding request has reported.
    task automatic drain_results();
        start = 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
    endtask

    task automatic apb_transfer(
        input logic              write,
        input logic [APB_AW-1:0] addr,
        input logic [31:0]       data
    );
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Writes a register with junk above its width, then reads the frame size back.
    task automatic set_register(input logic index, input logic [FSIZE_W-1:0] value);
        drain_results();
        apb_transfer(1'b1, reg_addr(index), ($urandom & ~32'h1FFF) | 32'(value));
        apb_transfer(1'b0, reg_addr(REG_FRAME_SIZE), 32'h0);
    endtask

    // Mostly well-formed allocates and frees, with some raw noise mixed in.
    task automatic random_request();
        int pick;
        int first;
        int cnt;
        pick  = $urandom_range(99);
        first = $urandom_range(NUM_FRAMES - 1);
        if (pick < 8) begin
            send_request(CMD_W'($urandom), START_W'($urandom), COUNT_W'($urandom));
        end else if (pick < 56) begin
            cnt = ($urandom_range(9) == 0) ? $urandom_range(13, NUM_FRAMES)
                                           : $urandom_range(1, 12);
            send_request(CMD_ALLOC, START_W'(first), COUNT_W'(cnt));
        end else if (pick < 61) begin
            first = $urandom_range(NUM_FRAMES / 2);
            cnt   = $urandom_range(16, NUM_FRAMES - first);
            send_request(CMD_FREE, START_W'(first), COUNT_W'(cnt));
        end else begin
            cnt = NUM_FRAMES - first;
            if (cnt > 16) begin
                cnt = 16;
            end
            cnt = $urandom_range(1, cnt);
            send_request(CMD_FREE, START_W'(first), COUNT_W'(cnt));
        end
        idle_sender();
    endtask

    initial begin
        int phase;
        int n;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_command     = CMD_ALLOC;
        i_start_frame = '0;
        i_frame_count = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_pct      = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part with the reset frame size: zero-length requests,
        // oversized allocates, frees past the end and of free frames, and
        // a hole too small for first fit.
        send_request(CMD_ALLOC, 6'd63, 7'd1);
        send_request(CMD_ALLOC, 6'd0, 7'd0);
        send_request(CMD_FREE, 6'd5, 7'd0);
        send_request(CMD_ALLOC, 6'd0, 7'd127);
        send_request(CMD_ALLOC, 6'd0, 7'd64);
        send_request(CMD_FREE, 6'd63, 7'd2);
        send_request(CMD_FREE, 6'd63, 7'd1);
        send_request(CMD_FREE, 6'd0, 7'd64);
        send_request(CMD_ALLOC, 6'd42, 7'd64);
        send_request(CMD_ALLOC, 6'd0, 7'd1);
        send_request(CMD_FREE, 6'd0, 7'd64);
        send_request(CMD_ALLOC, 6'd0, 7'd5);
        send_request(CMD_ALLOC, 6'd0, 7'd3);
        send_request(CMD_ALLOC, 6'd0, 7'd4);
        send_request(CMD_FREE, 6'd0, 7'd5);
        send_request(CMD_ALLOC, 6'd0, 7'd6);
        send_request(CMD_ALLOC, 6'd0, 7'd2);
        send_request(CMD_FREE, 6'd1, 7'd127);

        // Frame size zero and 4096, and a write to no register.
        set_register(REG_FRAME_SIZE, 13'd0);
        send_request(CMD_ALLOC, 6'd0, 7'd1);
        send_request(CMD_FREE, 6'd60, 7'd4);
        set_register(REG_FRAME_SIZE, 13'd4096);
        send_request(CMD_ALLOC, 6'd0, 7'd10);
        send_request(CMD_FREE, 6'd0, 7'd64);
        set_register(REG_SPARE, 13'h1FFF);
        send_request(CMD_ALLOC, 6'd63, 7'd1);

        // Random phases: light sender gaps, heavy gaps, then none.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 16;
                    set_register(REG_FRAME_SIZE, FSIZE_W'($urandom_range(1, 4096)));
                end
                1: begin
                    idle_pct = 82;
                    set_register(REG_FRAME_SIZE, 13'h1FFF);
                end
                default: begin
                    idle_pct = 0;
                    set_register(REG_FRAME_SIZE, 13'd1);
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Let the pipeline empty once in the middle of each phase.
                if (n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                random_request();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/ffa_pkg.sv
design/ffa_ctrl.sv
design/ffa_datapath.sv
design/first_fit_frame_allocator_core.sv
design/ffa_checker.sv
verif/ffa_checker.sv
verif/testbench.sv
